@@ rtl/core/qpt_pkg.sv @@
// Shared types and constants for the query path tokenizer.
package qpt_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned FIELD_POS_W   = 16;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STRING = 2'd1,
    KIND_NUMBER = 2'd2,
    KIND_IDENT  = 2'd3
  } qpt_kind_t;

  typedef enum logic [1:0] {
    PUNCT_NONE  = 2'd0,
    PUNCT_DOT   = 2'd1,
    PUNCT_OPEN  = 2'd2,
    PUNCT_CLOSE = 2'd3
  } qpt_punct_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_START  = 2'd1,
    ERR_NUMBER = 2'd2,
    ERR_IDENT  = 2'd3
  } qpt_err_t;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Token state carried from item to item
  typedef struct packed {
    qpt_kind_t token_kind;
    logic      double_quoted;
    qpt_err_t  failed_code;
  } qpt_state_t;

  // One result item
  typedef struct packed {
    qpt_kind_t              ended_kind;
    qpt_punct_t             punct_kind;
    qpt_kind_t              started_kind;
    logic                   appended;
    logic [7:0]             char_echo;
    qpt_err_t               error_code;
    logic [FIELD_POS_W-1:0] line_at;
    logic [FIELD_POS_W-1:0] column_at;
  } qpt_event_t;

endpackage

@@ rtl/core/qpt_if.sv @@
// Valid/ready channel interfaces for the tokenizer's input and result items.
interface qpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface qpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  ended_kind;
  logic [1:0]  punct_kind;
  logic [1:0]  started_kind;
  logic        appended;
  logic [7:0]  char_echo;
  logic [1:0]  error_code;
  logic [15:0] line_at;
  logic [15:0] column_at;

  modport source (output valid, output ended_kind, output punct_kind, output started_kind,
                  output appended, output char_echo, output error_code, output line_at,
                  output column_at, input ready);
  modport sink   (input valid, input ended_kind, input punct_kind, input started_kind,
                  input appended, input char_echo, input error_code, input line_at,
                  input column_at, output ready);
endinterface

@@ rtl/core/qpt_step.sv @@
// Per-character next-state and event logic of the tokenizer.
module qpt_step import qpt_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  qpt_state_t           st,
  input  logic [POS_WIDTH-1:0] line_cnt,
  input  logic [POS_WIDTH-1:0] col_cnt,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output qpt_state_t           st_nxt,
  output logic [POS_WIDTH-1:0] line_nxt,
  output logic [POS_WIDTH-1:0] col_nxt,
  output qpt_event_t           ev
);

  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

  logic is_digit;
  logic is_alpha;
  logic is_quote;
  logic is_punct;
  logic is_space;
  logic closes;
  logic [POS_WIDTH-1:0] col_inc;
  logic [POS_WIDTH-1:0] line_inc;
  qpt_err_t err;

  assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                    ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
  assign is_quote = (text_byte == CH_BSLASH) || (text_byte == CH_SQUOTE) ||
                    (text_byte == CH_DQUOTE);
  assign is_punct = (text_byte == CH_DOT) || (text_byte == CH_LBRK) ||
                    (text_byte == CH_RBRK);
  assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                    (text_byte == CH_NL) || (text_byte == CH_CR) || (text_byte == CH_FF);
  assign closes   = st.double_quoted ? (text_byte == CH_DQUOTE) : (text_byte == CH_SQUOTE);

  // saturating counters
  assign col_inc  = (&col_cnt)  ? col_cnt  : col_cnt  + POS_ONE;
  assign line_inc = (&line_cnt) ? line_cnt : line_cnt + POS_ONE;

  always_comb begin
    st_nxt          = st;
    line_nxt        = line_cnt;
    col_nxt         = col_cnt;
    err             = ERR_NONE;
    ev.ended_kind   = KIND_NONE;
    ev.punct_kind   = PUNCT_NONE;
    ev.started_kind = KIND_NONE;
    ev.appended     = 1'b0;
    ev.char_echo    = text_byte;
    ev.error_code   = ERR_NONE;
    ev.line_at      = FIELD_POS_W'(line_cnt);
    ev.column_at    = FIELD_POS_W'(col_cnt);
    if (end_of_text) begin
      ev.ended_kind    = (st.failed_code != ERR_NONE) ? KIND_NONE : st.token_kind;
      ev.error_code    = st.failed_code;
      ev.char_echo     = 8'h00;
      st_nxt.token_kind    = KIND_NONE;
      st_nxt.double_quoted = 1'b0;
      st_nxt.failed_code   = ERR_NONE;
      line_nxt = POS_ONE;
      col_nxt  = POS_ONE;
    end else if (st.failed_code != ERR_NONE) begin
      ev.error_code = st.failed_code;
    end else begin
      if (text_byte == CH_NL) begin
        line_nxt = line_inc;
        col_nxt  = POS_ONE;
      end else begin
        col_nxt = col_inc;
      end
      if (st.token_kind == KIND_STRING) begin
        if (closes) begin
          ev.ended_kind     = KIND_STRING;
          st_nxt.token_kind = KIND_NONE;
        end else begin
          ev.appended = 1'b1;
        end
      end else if (is_quote) begin
        ev.ended_kind        = st.token_kind;
        ev.started_kind      = KIND_STRING;
        st_nxt.token_kind    = KIND_STRING;
        st_nxt.double_quoted = (text_byte == CH_DQUOTE);
      end else if (is_punct) begin
        ev.ended_kind     = st.token_kind;
        st_nxt.token_kind = KIND_NONE;
        if (text_byte == CH_DOT) ev.punct_kind = PUNCT_DOT;
        else if (text_byte == CH_LBRK) ev.punct_kind = PUNCT_OPEN;
        else ev.punct_kind = PUNCT_CLOSE;
      end else if (is_space) begin
        ev.ended_kind     = st.token_kind;
        st_nxt.token_kind = KIND_NONE;
      end else if (st.token_kind == KIND_NONE) begin
        if (is_digit || (text_byte == CH_DASH)) begin
          st_nxt.token_kind = KIND_NUMBER;
          ev.started_kind   = KIND_NUMBER;
          ev.appended       = 1'b1;
        end else if (is_alpha || (text_byte == CH_UNDER)) begin
          st_nxt.token_kind = KIND_IDENT;
          ev.started_kind   = KIND_IDENT;
          ev.appended       = 1'b1;
        end else begin
          err = ERR_START;
        end
      end else if (st.token_kind == KIND_NUMBER) begin
        if (is_digit) ev.appended = 1'b1;
        else err = ERR_NUMBER;
      end else begin
        if (is_digit || is_alpha || (text_byte == CH_UNDER)) ev.appended = 1'b1;
        else err = ERR_IDENT;
      end
      st_nxt.failed_code = err;
      ev.error_code      = err;
      ev.line_at         = FIELD_POS_W'(line_nxt);
      ev.column_at       = FIELD_POS_W'(col_nxt);
    end
  end

endmodule

@@ rtl/core/query_path_tokenizer_core.sv @@
// Top level of the query path tokenizer: input register, token state, result register.
// One character enters per item and one result item leaves per item, with a sustained
// rate of one item per clock while the result side is ready. Each item passes the input
// register, then the result register. The rate is set by the token-state update, which is
// made as an item moves from the input register to the result register. Either
// side may stall; an item waits in the input register while a finished result is held.
// An end-of-text item flushes the pending token and returns the token state and line and column counters to reset.
module query_path_tokenizer_core import qpt_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  qpt_in_if.sink   in_chan,
  qpt_out_if.source out_chan
);

  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

  logic                 in_v_r;
  logic [7:0]           byte_r;
  logic                 eot_r;
  logic                 out_v_r;
  qpt_event_t           ev_r;
  qpt_state_t           st_r;
  logic [POS_WIDTH-1:0] line_r;
  logic [POS_WIDTH-1:0] col_r;

  qpt_state_t           st_nxt;
  logic [POS_WIDTH-1:0] line_nxt;
  logic [POS_WIDTH-1:0] col_nxt;
  qpt_event_t           ev_nxt;
  logic                 advance;
  logic                 in_take;

  assign advance        = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !in_v_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  qpt_step #(.POS_WIDTH(POS_WIDTH)) u_step (
    .st          (st_r),
    .line_cnt    (line_r),
    .col_cnt     (col_r),
    .text_byte   (byte_r),
    .end_of_text (eot_r),
    .st_nxt      (st_nxt),
    .line_nxt    (line_nxt),
    .col_nxt     (col_nxt),
    .ev          (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      st_r.token_kind    <= KIND_NONE;
      st_r.double_quoted <= 1'b0;
      st_r.failed_code   <= ERR_NONE;
      line_r   <= POS_ONE;
      col_r    <= POS_ONE;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_chan.text_byte;
      eot_r  <= in_chan.end_of_text;
    end
    if (advance) begin
      ev_r <= ev_nxt;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.ended_kind   = ev_r.ended_kind;
  assign out_chan.punct_kind   = ev_r.punct_kind;
  assign out_chan.started_kind = ev_r.started_kind;
  assign out_chan.appended     = ev_r.appended;
  assign out_chan.char_echo    = ev_r.char_echo;
  assign out_chan.error_code   = ev_r.error_code;
  assign out_chan.line_at      = ev_r.line_at;
  assign out_chan.column_at    = ev_r.column_at;

`ifndef SYNTH
  // a held error is reported on every following character
  a_sticky_err: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !eot_r && (st_r.failed_code != ERR_NONE))
      |=> (out_chan.error_code == $past(st_r.failed_code)) && (st_r == $past(st_r)))
    else $error("held error not reported");

  // end of text returns the token state to reset
  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && eot_r)
      |=> (st_r.token_kind == KIND_NONE) && (st_r.failed_code == ERR_NONE) &&
          (line_r == POS_ONE) && (col_r == POS_ONE))
    else $error("end of text did not clear state");

  // an item waiting behind a stalled result is kept
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> in_v_r && $stable(byte_r) && $stable(eot_r))
    else $error("input item lost while stalled");
`endif

endmodule

@@ sim/qpt_event_checker.sv @@
`timescale 1ns / 100ps
// Tokenizer result checker: predicts one event per accepted character and compares results.
module qpt_event_checker import qpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  qpt_in_if    in_chan,
  qpt_out_if   out_chan,
  output int   fail_count,
  output int   pending_count
);

  localparam int unsigned POS_W = POS_WIDTH_DEF;
  localparam logic [POS_W-1:0] POS_LIMIT = '1;

  qpt_kind_t        tok_kind;
  logic             tok_dq;
  logic [POS_W-1:0] line_cnt;
  logic [POS_W-1:0] col_cnt;
  qpt_err_t         held_err;

  qpt_event_t expected_events[$];

  function automatic void clear_tokenizer();
    tok_kind = KIND_NONE;
    tok_dq   = 1'b0;
    line_cnt = POS_W'(1);
    col_cnt  = POS_W'(1);
    held_err = ERR_NONE;
  endfunction

  function automatic logic [POS_W-1:0] bump(logic [POS_W-1:0] v);
    return (v == POS_LIMIT) ? v : v + 1'b1;
  endfunction

  function automatic bit is_digit(logic [7:0] ch);
    return ch inside {["0":"9"]};
  endfunction

  function automatic bit is_alpha(logic [7:0] ch);
    return (ch inside {["a":"z"]}) || (ch inside {["A":"Z"]});
  endfunction

  function automatic qpt_event_t next_event(logic [7:0] ch, logic eot);
    qpt_event_t ev;
    qpt_err_t   err;
    ev  = '0;
    err = ERR_NONE;
    if (eot) begin
      ev.ended_kind = (held_err == ERR_NONE) ? tok_kind : KIND_NONE;
      ev.error_code = held_err;
      ev.line_at    = line_cnt[FIELD_POS_W-1:0];
      ev.column_at  = col_cnt[FIELD_POS_W-1:0];
      clear_tokenizer();
      return ev;
    end
    ev.char_echo = ch;
    if (held_err != ERR_NONE) begin
      ev.error_code = held_err;
    end else begin
      col_cnt = bump(col_cnt);
      if (ch == CH_NL) begin
        line_cnt = bump(line_cnt);
        col_cnt  = POS_W'(1);
      end
      if (tok_kind == KIND_STRING) begin
        if (ch == (tok_dq ? CH_DQUOTE : CH_SQUOTE)) begin
          ev.ended_kind = KIND_STRING;
          tok_kind      = KIND_NONE;
        end else begin
          ev.appended = 1'b1;
        end
      end else if (ch == CH_BSLASH || ch == CH_SQUOTE || ch == CH_DQUOTE) begin
        // backslash opens a string closed by a single quote
        ev.ended_kind   = tok_kind;
        ev.started_kind = KIND_STRING;
        tok_kind        = KIND_STRING;
        tok_dq          = (ch == CH_DQUOTE);
      end else if (ch == CH_DOT || ch == CH_LBRK || ch == CH_RBRK) begin
        ev.ended_kind = tok_kind;
        ev.punct_kind = (ch == CH_DOT) ? PUNCT_DOT : (ch == CH_LBRK) ? PUNCT_OPEN : PUNCT_CLOSE;
        tok_kind      = KIND_NONE;
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL || ch == CH_CR
                   || ch == CH_FF) begin
        ev.ended_kind = tok_kind;
        tok_kind      = KIND_NONE;
      end else begin
        case (tok_kind)
          KIND_NONE: begin
            if (is_digit(ch) || ch == CH_DASH) begin
              tok_kind        = KIND_NUMBER;
              ev.started_kind = KIND_NUMBER;
              ev.appended     = 1'b1;
            end else if (is_alpha(ch) || ch == CH_UNDER) begin
              tok_kind        = KIND_IDENT;
              ev.started_kind = KIND_IDENT;
              ev.appended     = 1'b1;
            end else begin
              err = ERR_START;
            end
          end
          KIND_NUMBER: begin
            if (is_digit(ch)) ev.appended = 1'b1;
            else err = ERR_NUMBER;
          end
          default: begin
            if (is_digit(ch) || is_alpha(ch) || ch == CH_UNDER) ev.appended = 1'b1;
            else err = ERR_IDENT;
          end
        endcase
      end
      if (err != ERR_NONE) begin
        held_err      = err;
        ev.error_code = err;
      end
    end
    ev.line_at   = line_cnt[FIELD_POS_W-1:0];
    ev.column_at = col_cnt[FIELD_POS_W-1:0];
    return ev;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    clear_tokenizer();
  end

  always @(posedge clk) begin
    qpt_event_t want_ev;
    qpt_event_t pred_ev;
    if (!rst_n) begin
      clear_tokenizer();
      expected_events.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result item, char_echo %0d expected none",
                   $time, out_chan.char_echo);
          fail_count++;
        end else begin
          want_ev = expected_events.pop_front();
          check_field("ended_kind",   want_ev.ended_kind,   out_chan.ended_kind);
          check_field("punct_kind",   want_ev.punct_kind,   out_chan.punct_kind);
          check_field("started_kind", want_ev.started_kind, out_chan.started_kind);
          check_field("appended",     want_ev.appended,     out_chan.appended);
          check_field("char_echo",    want_ev.char_echo,    out_chan.char_echo);
          check_field("error_code",   want_ev.error_code,   out_chan.error_code);
          check_field("line_at",      want_ev.line_at,      out_chan.line_at);
          check_field("column_at",    want_ev.column_at,    out_chan.column_at);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        pred_ev = next_event(in_chan.text_byte, in_chan.end_of_text);
        expected_events.insert(expected_events.size(), pred_ev);
      end
    end
    pending_count = expected_events.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Tokenizer regression top: clock, reset, character stimulus, result back-pressure, verdict.
module tb_top;
  import qpt_pkg::*;

  localparam int    RANDOM_ITEMS = 900;
  localparam string IDENT_HEAD   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string DIGITS       = "0123456789";

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_sent;
  int   burst_left;

  qpt_in_if  in_chan();
  qpt_out_if out_chan();

  query_path_tokenizer_core #(.POS_WIDTH(POS_WIDTH_DEF)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  qpt_event_checker event_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic push_char(logic [7:0] ch, logic eot, bit paced);
    int idle;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (idle) begin
          @(negedge clk);
          in_chan.valid       <= 1'b0;
          in_chan.text_byte   <= 8'($urandom);
          in_chan.end_of_text <= 1'($urandom_range(0, 1));
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_chan.valid       <= 1'b1;
    in_chan.text_byte   <= ch;
    in_chan.end_of_text <= eot;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0, 1'b1);
  endtask

  task automatic send_fast(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0, 1'b0);
  endtask

  task automatic end_text();
    push_char(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  // mostly well-formed path with random tokens; now and then one stray byte or an unclosed string
  task automatic random_text();
    int         n_tok;
    int         noise_at;
    int         len;
    logic [7:0] closer;
    logic [7:0] ch;
    n_tok    = $urandom_range(1, 8);
    noise_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_tok - 1) : -1;
    for (int t = 0; t < n_tok; t++) begin
      if (t == noise_at) push_char(8'($urandom), 1'b0, 1'b1);
      case ($urandom_range(0, 3))
        0: begin
          push_char(pick(IDENT_HEAD), 1'b0, 1'b1);
          len = $urandom_range(0, 6);
          repeat (len) push_char(($urandom_range(0, 2) == 0) ? pick(DIGITS) : pick(IDENT_HEAD),
                                 1'b0, 1'b1);
        end
        1: begin
          if ($urandom_range(0, 2) == 0) push_char(CH_DASH, 1'b0, 1'b1);
          len = $urandom_range(1, 5);
          repeat (len) push_char(pick(DIGITS), 1'b0, 1'b1);
        end
        2: begin
          case ($urandom_range(0, 2))
            0:       ch = CH_SQUOTE;
            1:       ch = CH_DQUOTE;
            default: ch = CH_BSLASH;
          endcase
          closer = (ch == CH_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
          push_char(ch, 1'b0, 1'b1);
          len = $urandom_range(0, 6);
          repeat (len) begin
            do ch = 8'($urandom); while (ch == closer);
            push_char(ch, 1'b0, 1'b1);
          end
          if ($urandom_range(0, 7) != 0) push_char(closer, 1'b0, 1'b1);
        end
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0:       ch = CH_DOT;
        1:       ch = CH_LBRK;
        2:       ch = CH_RBRK;
        3:       ch = CH_SPACE;
        4:       ch = CH_TAB;
        5:       ch = CH_NL;
        6:       ch = CH_CR;
        default: ch = CH_FF;
      endcase
      push_char(ch, 1'b0, 1'b1);
    end
    end_text();
  endtask

  // result side: mixed stall patterns, plus a long hold-off now and then
  initial begin
    int cyc;
    int next_hold;
    int run;
    int mode;
    bit rdy;
    out_chan.ready = 1'b0;
    cyc       = 0;
    next_hold = 400;
    forever begin
      if (cyc >= next_hold) begin
        repeat (60) begin
          @(negedge clk);
          out_chan.ready <= 1'b0;
        end
        cyc += 60;
        next_hold = cyc + $urandom_range(1500, 4000);
      end
      mode = $urandom_range(0, 3);
      run  = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(4, 40);
      repeat (run) begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 1);
          2:       rdy = ($urandom_range(0, 3) != 0);
          default: rdy = 1'b0;
        endcase
        @(negedge clk);
        out_chan.ready <= rdy;
        cyc++;
      end
    end
  end

  initial begin
    int mark;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.text_byte   = '0;
    in_chan.end_of_text = 1'b0;
    items_sent          = 0;
    burst_left          = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // punctuation, numbers, identifiers, whitespace
    send_text("_a9[-7]. \t");
    push_char(CH_CR, 1'b0, 1'b1);
    push_char(CH_FF, 1'b0, 1'b1);
    // quoted strings, other quote inside, open string flushed at end
    send_text("'\"\\'\"'x");
    end_text();
    // bad number char, then sticky error
    send_text("9az");
    end_text();
    send_text("k-");
    end_text();
    push_char(8'hFF, 1'b0, 1'b1);
    end_text();

    mark = items_sent;
    while (items_sent - mark < RANDOM_ITEMS / 2) random_text();
    drain();

    // back to back, bad identifier char
    send_fast("x1.[42] 'q'\n-3\n");
    send_text("ab#z");
    end_text();

    mark = items_sent;
    while (items_sent - mark < RANDOM_ITEMS / 2) random_text();

    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
